// ===== hw/rtl/flt_pkg.sv =====
package flt_pkg;

    localparam int MAX_FLAMES_DEF   = 16;
    localparam int MAX_FRACTION_DEF = 64;
    localparam int MAX_VARIANCE_DEF = 32;

    localparam int VAL_W = 32;
    localparam int W_W   = 17;
    localparam logic [W_W-1:0] W_ONE = 17'h10000;

    typedef enum logic [2:0] {
        OP_LOAD_RATE  = 3'd0,
        OP_LOAD_FRAC  = 3'd1,
        OP_LOAD_VAR   = 3'd2,
        OP_LOAD_TABLE = 3'd3,
        OP_QUERY      = 3'd4
    } opcode_t;

    localparam logic [1:0] CFG_FLAMES   = 2'd0;
    localparam logic [1:0] CFG_FRACTION = 2'd1;
    localparam logic [1:0] CFG_VARIANCE = 2'd2;

    typedef enum logic [1:0] {
        SEL_RATE,
        SEL_FRAC,
        SEL_VAR
    } wsel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_R0_RD,
        ST_R0_CMP,
        ST_RL_RD,
        ST_RL_CMP,
        ST_RS_RD,
        ST_RS_CMP,
        ST_W_GO,
        ST_W_WAIT,
        ST_F_START,
        ST_A0_RD,
        ST_A0_CMP,
        ST_AS_RD,
        ST_AS_CMP,
        ST_T_RD,
        ST_T_CAP,
        ST_L_ISS,
        ST_L_WR,
        ST_DONE
    } fsm_t;

    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } wgt_req_t;

    typedef struct packed {
        logic           done;
        logic [W_W-1:0] w;
    } wgt_rsp_t;

endpackage

// ===== hw/rtl/flt_store.sv =====
module flt_store import flt_pkg::*; #(
    parameter int MAX_FLAMES          = MAX_FLAMES_DEF,
    parameter int MAX_FRACTION_POINTS = MAX_FRACTION_DEF,
    parameter int MAX_VARIANCE_POINTS = MAX_VARIANCE_DEF,
    localparam int FL_IW = (MAX_FLAMES > 1) ? $clog2(MAX_FLAMES) : 1,
    localparam int FA_AW = $clog2(MAX_FLAMES * MAX_FRACTION_POINTS),
    localparam int VA_AW = $clog2(MAX_FLAMES * MAX_VARIANCE_POINTS),
    localparam int TB_AW = $clog2(MAX_FLAMES * MAX_FRACTION_POINTS * MAX_VARIANCE_POINTS)
) (
    input  logic               aclk,
    input  logic [VAL_W-1:0]   ax_wdata,
    input  logic               bp_we,
    input  logic [FL_IW-1:0]   bp_waddr,
    input  logic [FL_IW-1:0]   bp_raddr,
    output logic [VAL_W-1:0]   bp_rdata,
    input  logic               fa_we,
    input  logic [FA_AW-1:0]   fa_waddr,
    input  logic [FA_AW-1:0]   fa_raddr,
    output logic [VAL_W-1:0]   fa_rdata,
    input  logic               va_we,
    input  logic [VA_AW-1:0]   va_waddr,
    input  logic [VA_AW-1:0]   va_raddr,
    output logic [VAL_W-1:0]   va_rdata,
    input  logic               tb_we,
    input  logic [TB_AW-1:0]   tb_waddr,
    input  logic [4*VAL_W-1:0] tb_wdata,
    input  logic [TB_AW-1:0]   tb_raddr,
    output logic [4*VAL_W-1:0] tb_rdata
);

    logic [VAL_W-1:0]   bp_mem [MAX_FLAMES];
    logic [VAL_W-1:0]   fa_mem [MAX_FLAMES * MAX_FRACTION_POINTS];
    logic [VAL_W-1:0]   va_mem [MAX_FLAMES * MAX_VARIANCE_POINTS];
    logic [4*VAL_W-1:0] tb_mem [MAX_FLAMES * MAX_FRACTION_POINTS * MAX_VARIANCE_POINTS];

    always_ff @(posedge aclk) begin
        if (bp_we) begin
            bp_mem[bp_waddr] <= ax_wdata;
        end
        bp_rdata <= bp_mem[bp_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fa_we) begin
            fa_mem[fa_waddr] <= ax_wdata;
        end
        fa_rdata <= fa_mem[fa_raddr];
    end

    always_ff @(posedge aclk) begin
        if (va_we) begin
            va_mem[va_waddr] <= ax_wdata;
        end
        va_rdata <= va_mem[va_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tb_we) begin
            tb_mem[tb_waddr] <= tb_wdata;
        end
        tb_rdata <= tb_mem[tb_raddr];
    end

endmodule

// ===== hw/rtl/flt_weight.sv =====
module flt_weight import flt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  wgt_req_t req,
    output wgt_rsp_t rsp
);

    logic signed [VAL_W:0] num;
    logic signed [VAL_W:0] den;
    logic                  busy_reg;
    logic                  done_reg;
    logic [3:0]            cnt_reg;
    logic [VAL_W-1:0]      rem_reg;
    logic [VAL_W-1:0]      den_reg;
    logic [W_W-1:0]        q_reg;
    logic [VAL_W:0]        sh;

    assign num = {req.x[VAL_W-1], req.x} - {req.lo[VAL_W-1], req.lo};
    assign den = {req.hi[VAL_W-1], req.hi} - {req.lo[VAL_W-1], req.lo};
    assign sh  = {rem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (den <= 0 || num <= 0) begin
                    done_reg <= 1'b1;
                end else if (num >= den) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= num[VAL_W-1:0];
            den_reg <= den[VAL_W-1:0];
            if (den <= 0 || num <= 0) begin
                q_reg <= '0;
            end else if (num >= den) begin
                q_reg <= W_ONE;
            end else begin
                q_reg <= '0;
            end
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_reg <= VAL_W'(sh - {1'b0, den_reg});
                q_reg   <= {q_reg[W_W-2:0], 1'b1};
            end else begin
                rem_reg <= sh[VAL_W-1:0];
                q_reg   <= {q_reg[W_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.w    = q_reg;

endmodule

// ===== hw/rtl/flamelet_table_interpolator_top.sv =====
// channel | dir | signals                                | contents
// s_      | in  | s_tvalid s_tready s_tdata s_tuser      | load or query item
// m_      | out | m_tvalid m_tready m_tdata m_tuser      | interpolated properties
// cfg_    | in  | cfg_valid cfg_ready cfg_index cfg_data | register writes
// Load items write the stores at acceptance.
// Query: scan the rate breakpoints, then per flame scan each axis, run the weight divider,
//   read the four table corners and lerp, and blend the two flames when the rate lies between;
//   the time is set by the single read port scans, the bit-serial weight divider and one multiplier.
// Reset clears control and the registers to 16, 64, 32; the stores hold garbage until loaded.
// A finished result waits in ST_DONE until the output register is free; s_tready stays low until then.
module flamelet_table_interpolator_top import flt_pkg::*; #(
    parameter int MAX_FLAMES          = MAX_FLAMES_DEF,
    parameter int MAX_FRACTION_POINTS = MAX_FRACTION_DEF,
    parameter int MAX_VARIANCE_POINTS = MAX_VARIANCE_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // flame_index, row_index, column_index, axis_value, load_temperature, load_density,
    // load_heat_capacity, load_absorption, mixture_fraction, mixture_variance,
    // dissipation_rate, zero pad
    input  logic [271:0] s_tdata,
    // opcode
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // temperature_out, density_out, heat_capacity_out, absorption_out
    output logic [127:0] m_tdata,
    // clamped_flag
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int FL_IW = (MAX_FLAMES > 1) ? $clog2(MAX_FLAMES) : 1;
    localparam int FR_IW = $clog2(MAX_FRACTION_POINTS);
    localparam int VR_IW = $clog2(MAX_VARIANCE_POINTS);
    localparam int AX_IW = (FR_IW > VR_IW) ? FR_IW : VR_IW;
    localparam int FA_AW = $clog2(MAX_FLAMES * MAX_FRACTION_POINTS);
    localparam int VA_AW = $clog2(MAX_FLAMES * MAX_VARIANCE_POINTS);
    localparam int TB_AW = $clog2(MAX_FLAMES * MAX_FRACTION_POINTS * MAX_VARIANCE_POINTS);
    localparam int FLAME_SPAN = MAX_FRACTION_POINTS * MAX_VARIANCE_POINTS;

    logic [3:0]  s_flame;
    logic [5:0]  s_row;
    logic [4:0]  s_col;
    logic [31:0] s_axis;
    logic [31:0] s_xf;
    logic [31:0] s_xv;
    logic [31:0] s_chi;
    logic [31:0] fl32;
    logic [31:0] row32;
    logic [31:0] col32;
    logic        s_accept;
    logic        fl_ok;

    assign s_flame = s_tdata[3:0];
    assign s_row   = s_tdata[9:4];
    assign s_col   = s_tdata[14:10];
    assign s_axis  = s_tdata[46:15];
    assign s_xf    = s_tdata[206:175];
    assign s_xv    = s_tdata[238:207];
    assign s_chi   = s_tdata[270:239];
    assign fl32    = 32'(s_flame);
    assign row32   = 32'(s_row);
    assign col32   = 32'(s_col);
    assign fl_ok   = fl32 < 32'(MAX_FLAMES);

    logic [4:0] flames_reg;
    logic [6:0] frac_reg;
    logic [5:0] var_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flames_reg <= 5'd16;
            frac_reg   <= 7'd64;
            var_reg    <= 6'd32;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FLAMES:   flames_reg <= cfg_data[4:0];
                CFG_FRACTION: frac_reg   <= cfg_data;
                CFG_VARIANCE: var_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [31:0] nfl32;
    logic [31:0] nfr32;
    logic [31:0] nvr32;

    always_comb begin
        if (flames_reg == '0) begin
            nfl32 = 32'd1;
        end else if (32'(flames_reg) > 32'(MAX_FLAMES)) begin
            nfl32 = 32'(MAX_FLAMES);
        end else begin
            nfl32 = 32'(flames_reg);
        end
        if (32'(frac_reg) < 32'd2) begin
            nfr32 = 32'd2;
        end else if (32'(frac_reg) > 32'(MAX_FRACTION_POINTS)) begin
            nfr32 = 32'(MAX_FRACTION_POINTS);
        end else begin
            nfr32 = 32'(frac_reg);
        end
        if (32'(var_reg) < 32'd2) begin
            nvr32 = 32'd2;
        end else if (32'(var_reg) > 32'(MAX_VARIANCE_POINTS)) begin
            nvr32 = 32'(MAX_VARIANCE_POINTS);
        end else begin
            nvr32 = 32'(var_reg);
        end
    end

    fsm_t  state_reg, state_next;
    wsel_t sel_reg;

    logic signed [31:0] xf_reg, xv_reg, chi_reg, x_reg, prev_reg, lo_reg, hi_reg;
    logic               flag_reg, two_reg, second_reg;
    logic [FL_IW-1:0]   cur_reg, fb_reg, j_rate_reg;
    logic [AX_IW-1:0]   j_ax_reg;
    logic [FR_IW-1:0]   r0_reg;
    logic [VR_IW-1:0]   c0_reg;
    logic [W_W-1:0]     wr_reg, wc_reg, wchi_reg;
    logic [1:0]         q_reg, ph_reg, k_reg;
    logic signed [31:0] t0_reg [4];
    logic signed [31:0] t1_reg [4];
    logic signed [31:0] t2_reg [4];
    logic signed [31:0] t3_reg [4];
    logic signed [31:0] a_reg  [4];
    logic signed [31:0] b_reg  [4];
    logic signed [31:0] v_reg  [4];
    logic signed [31:0] va_reg [4];
    logic signed [31:0] o_reg  [4];
    logic signed [47:0] prod_reg;
    logic signed [31:0] ya_reg;
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;
    logic               m_flag_reg;

    logic [31:0]        fl_last32;
    logic [31:0]        ax_last32;
    logic [FL_IW-1:0]   fl_last;
    logic [FL_IW-1:0]   j_rate_m1;
    logic [AX_IW-1:0]   j_ax_m1;
    logic signed [31:0] bp_d, ax_d;
    logic               ax_hit;
    logic               out_free;
    logic signed [31:0] op_a, op_b;
    logic [W_W-1:0]     op_w;
    logic signed [32:0] diff;
    logic signed [31:0] res;

    logic               bp_we, fa_we, va_we, tb_we;
    logic [FL_IW-1:0]   bp_waddr, bp_raddr;
    logic [FA_AW-1:0]   fa_waddr, fa_raddr;
    logic [VA_AW-1:0]   va_waddr, va_raddr;
    logic [TB_AW-1:0]   tb_waddr, tb_raddr;
    logic [31:0]        bp_rdata, fa_rdata, va_rdata;
    logic [127:0]       tb_rdata;
    wgt_req_t           wreq;
    wgt_rsp_t           wrsp;

    assign fl_last32 = nfl32 - 32'd1;
    assign fl_last   = fl_last32[FL_IW-1:0];
    assign ax_last32 = ((sel_reg == SEL_FRAC) ? nfr32 : nvr32) - 32'd1;
    assign j_rate_m1 = j_rate_reg - 1'b1;
    assign j_ax_m1   = j_ax_reg - 1'b1;
    assign bp_d      = $signed(bp_rdata);
    assign ax_d      = (sel_reg == SEL_FRAC) ? $signed(fa_rdata) : $signed(va_rdata);
    assign ax_hit    = (x_reg <= ax_d) || (32'(j_ax_reg) == ax_last32);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    assign bp_we    = s_accept && s_tuser == OP_LOAD_RATE && fl_ok;
    assign fa_we    = s_accept && s_tuser == OP_LOAD_FRAC && fl_ok
                      && row32 < 32'(MAX_FRACTION_POINTS);
    assign va_we    = s_accept && s_tuser == OP_LOAD_VAR && fl_ok
                      && col32 < 32'(MAX_VARIANCE_POINTS);
    assign tb_we    = s_accept && s_tuser == OP_LOAD_TABLE && fl_ok
                      && row32 < 32'(MAX_FRACTION_POINTS) && col32 < 32'(MAX_VARIANCE_POINTS);
    assign bp_waddr = FL_IW'(fl32);
    assign fa_waddr = FA_AW'(fl32) * FA_AW'(MAX_FRACTION_POINTS) + FA_AW'(row32);
    assign va_waddr = VA_AW'(fl32) * VA_AW'(MAX_VARIANCE_POINTS) + VA_AW'(col32);
    assign tb_waddr = TB_AW'(fl32) * TB_AW'(FLAME_SPAN)
                      + TB_AW'(row32) * TB_AW'(MAX_VARIANCE_POINTS) + TB_AW'(col32);

    assign fa_raddr = FA_AW'(cur_reg) * FA_AW'(MAX_FRACTION_POINTS) + FA_AW'(j_ax_reg);
    assign va_raddr = VA_AW'(cur_reg) * VA_AW'(MAX_VARIANCE_POINTS) + VA_AW'(j_ax_reg);
    assign tb_raddr = TB_AW'(cur_reg) * TB_AW'(FLAME_SPAN)
                      + (TB_AW'(r0_reg) + TB_AW'(q_reg[0])) * TB_AW'(MAX_VARIANCE_POINTS)
                      + TB_AW'(c0_reg) + TB_AW'(q_reg[1]);

    flt_store #(
        .MAX_FLAMES          (MAX_FLAMES),
        .MAX_FRACTION_POINTS (MAX_FRACTION_POINTS),
        .MAX_VARIANCE_POINTS (MAX_VARIANCE_POINTS)
    ) u_store (
        .aclk     (aclk),
        .ax_wdata (s_axis),
        .bp_we    (bp_we),
        .bp_waddr (bp_waddr),
        .bp_raddr (bp_raddr),
        .bp_rdata (bp_rdata),
        .fa_we    (fa_we),
        .fa_waddr (fa_waddr),
        .fa_raddr (fa_raddr),
        .fa_rdata (fa_rdata),
        .va_we    (va_we),
        .va_waddr (va_waddr),
        .va_raddr (va_raddr),
        .va_rdata (va_rdata),
        .tb_we    (tb_we),
        .tb_waddr (tb_waddr),
        .tb_wdata (s_tdata[174:47]),
        .tb_raddr (tb_raddr),
        .tb_rdata (tb_rdata)
    );

    flt_weight u_weight (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (wreq),
        .rsp     (wrsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser == OP_QUERY) state_next = ST_R0_RD;
            end
            ST_R0_RD:  state_next = ST_R0_CMP;
            ST_R0_CMP: state_next = (chi_reg <= bp_d) ? ST_F_START : ST_RL_RD;
            ST_RL_RD:  state_next = ST_RL_CMP;
            ST_RL_CMP: state_next = (chi_reg >= bp_d) ? ST_F_START : ST_RS_RD;
            ST_RS_RD:  state_next = ST_RS_CMP;
            ST_RS_CMP: state_next = (chi_reg <= bp_d) ? ST_W_GO : ST_RS_RD;
            ST_W_GO:   state_next = ST_W_WAIT;
            ST_W_WAIT: begin
                if (wrsp.done) begin
                    case (sel_reg)
                        SEL_RATE: state_next = ST_F_START;
                        SEL_FRAC: state_next = ST_A0_RD;
                        default:  state_next = ST_T_RD;
                    endcase
                end
            end
            ST_F_START: state_next = ST_A0_RD;
            ST_A0_RD:   state_next = ST_A0_CMP;
            ST_A0_CMP:  state_next = ST_AS_RD;
            ST_AS_RD:   state_next = ST_AS_CMP;
            ST_AS_CMP:  state_next = ax_hit ? ST_W_GO : ST_AS_RD;
            ST_T_RD:    state_next = ST_T_CAP;
            ST_T_CAP:   state_next = (q_reg == 2'd3) ? ST_L_ISS : ST_T_RD;
            ST_L_ISS:   state_next = ST_L_WR;
            ST_L_WR: begin
                if (k_reg != 2'd3) begin
                    state_next = ST_L_ISS;
                end else begin
                    case (ph_reg)
                        2'd0, 2'd1: state_next = ST_L_ISS;
                        2'd2: begin
                            if (two_reg && !second_reg) state_next = ST_F_START;
                            else if (two_reg) state_next = ST_L_ISS;
                            else state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_R0_RD: bp_raddr = '0;
            ST_RL_RD: bp_raddr = fl_last;
            default:  bp_raddr = j_rate_reg;
        endcase
        wreq.start = (state_reg == ST_W_GO);
        wreq.x     = x_reg;
        wreq.lo    = lo_reg;
        wreq.hi    = hi_reg;
        case (ph_reg)
            2'd0: begin
                op_a = t0_reg[0];
                op_b = t1_reg[0];
                op_w = wr_reg;
            end
            2'd1: begin
                op_a = t2_reg[0];
                op_b = t3_reg[0];
                op_w = wr_reg;
            end
            2'd2: begin
                op_a = a_reg[0];
                op_b = b_reg[0];
                op_w = wc_reg;
            end
            default: begin
                op_a = va_reg[0];
                op_b = v_reg[0];
                op_w = wchi_reg;
            end
        endcase
        diff = {op_b[31], op_b} - {op_a[31], op_a};
        res  = ya_reg + prod_reg[47:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                xf_reg     <= $signed(s_xf);
                xv_reg     <= $signed(s_xv);
                chi_reg    <= $signed(s_chi);
                flag_reg   <= 1'b0;
                two_reg    <= 1'b0;
                second_reg <= 1'b0;
            end
            ST_R0_CMP: begin
                prev_reg   <= bp_d;
                cur_reg    <= '0;
                j_rate_reg <= FL_IW'(1);
                if (chi_reg < bp_d) flag_reg <= 1'b1;
            end
            ST_RL_CMP: begin
                cur_reg <= fl_last;
                if (chi_reg > bp_d) flag_reg <= 1'b1;
            end
            ST_RS_CMP: begin
                if (chi_reg <= bp_d) begin
                    cur_reg <= j_rate_m1;
                    fb_reg  <= j_rate_reg;
                    two_reg <= 1'b1;
                    sel_reg <= SEL_RATE;
                    x_reg   <= chi_reg;
                    lo_reg  <= prev_reg;
                    hi_reg  <= bp_d;
                end else begin
                    prev_reg   <= bp_d;
                    j_rate_reg <= j_rate_reg + 1'b1;
                end
            end
            ST_W_WAIT: begin
                if (wrsp.done) begin
                    case (sel_reg)
                        SEL_RATE: wchi_reg <= wrsp.w;
                        SEL_FRAC: begin
                            wr_reg   <= wrsp.w;
                            sel_reg  <= SEL_VAR;
                            x_reg    <= xv_reg;
                            j_ax_reg <= '0;
                        end
                        default: begin
                            wc_reg <= wrsp.w;
                            q_reg  <= '0;
                        end
                    endcase
                end
            end
            ST_F_START: begin
                sel_reg  <= SEL_FRAC;
                x_reg    <= xf_reg;
                j_ax_reg <= '0;
                ph_reg   <= '0;
                k_reg    <= '0;
                if (second_reg) begin
                    for (int i = 0; i < 4; i++) va_reg[i] <= v_reg[i];
                end
            end
            ST_A0_CMP: begin
                if (x_reg < ax_d) begin
                    x_reg    <= ax_d;
                    flag_reg <= 1'b1;
                end
                prev_reg <= ax_d;
                j_ax_reg <= AX_IW'(1);
            end
            ST_AS_CMP: begin
                if (ax_hit) begin
                    if (!(x_reg <= ax_d)) begin
                        x_reg    <= ax_d;
                        flag_reg <= 1'b1;
                    end
                    lo_reg <= prev_reg;
                    hi_reg <= ax_d;
                    if (sel_reg == SEL_FRAC) r0_reg <= FR_IW'(j_ax_m1);
                    else c0_reg <= VR_IW'(j_ax_m1);
                end else begin
                    prev_reg <= ax_d;
                    j_ax_reg <= j_ax_reg + 1'b1;
                end
            end
            ST_T_CAP: begin
                for (int i = 0; i < 4; i++) begin
                    case (q_reg)
                        2'd0:    t0_reg[i] <= $signed(tb_rdata[32*i +: 32]);
                        2'd1:    t1_reg[i] <= $signed(tb_rdata[32*i +: 32]);
                        2'd2:    t2_reg[i] <= $signed(tb_rdata[32*i +: 32]);
                        default: t3_reg[i] <= $signed(tb_rdata[32*i +: 32]);
                    endcase
                end
                q_reg <= q_reg + 2'd1;
            end
            ST_L_ISS: begin
                prod_reg <= 48'(diff * $signed({1'b0, op_w}));
                ya_reg   <= op_a;
            end
            ST_L_WR: begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd2 && two_reg && !second_reg) begin
                        second_reg <= 1'b1;
                        cur_reg    <= fb_reg;
                    end
                end
                case (ph_reg)
                    2'd0: begin
                        for (int i = 0; i < 3; i++) begin
                            t0_reg[i] <= t0_reg[i+1];
                            t1_reg[i] <= t1_reg[i+1];
                            a_reg[i]  <= a_reg[i+1];
                        end
                        a_reg[3] <= res;
                    end
                    2'd1: begin
                        for (int i = 0; i < 3; i++) begin
                            t2_reg[i] <= t2_reg[i+1];
                            t3_reg[i] <= t3_reg[i+1];
                            b_reg[i]  <= b_reg[i+1];
                        end
                        b_reg[3] <= res;
                    end
                    2'd2: begin
                        for (int i = 0; i < 3; i++) begin
                            a_reg[i] <= a_reg[i+1];
                            b_reg[i] <= b_reg[i+1];
                            v_reg[i] <= v_reg[i+1];
                        end
                        v_reg[3] <= res;
                    end
                    default: begin
                        for (int i = 0; i < 3; i++) begin
                            va_reg[i] <= va_reg[i+1];
                            v_reg[i]  <= v_reg[i+1];
                            o_reg[i]  <= o_reg[i+1];
                        end
                        o_reg[3] <= res;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_flag_reg <= flag_reg;
            if (two_reg) begin
                m_data_reg <= {o_reg[3], o_reg[2], o_reg[1], o_reg[0]};
            end else begin
                m_data_reg <= {v_reg[3], v_reg[2], v_reg[1], v_reg[0]};
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_flag_reg;

endmodule
